@@ hw/rtl/tdes_pkg.sv @@
// Package: DES permutation tables, S-boxes and helper functions for the 3DES core.
package tdes_pkg;

	typedef logic [63:0] blk_t;
	typedef logic [47:0] subkey_t;

	localparam int NumRounds = 48;

	typedef enum logic [0:0] {
		REG_KEY_LEFT  = 1'b0,
		REG_KEY_RIGHT = 1'b1
	} reg_idx_t;

	typedef logic [5:0] tab64_t [64];
	typedef logic [5:0] tab56_t [56];
	typedef logic [5:0] tab48_t [48];
	typedef logic [4:0] tab32_t [32];
	typedef logic [3:0] sbox_t [8][64];

	localparam tab64_t IpTab = '{
		57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7,
		56,48,40,32,24,16,8,0, 58,50,42,34,26,18,10,2,
		60,52,44,36,28,20,12,4, 62,54,46,38,30,22,14,6};
	localparam tab64_t FpTab = '{
		39,7,47,15,55,23,63,31, 38,6,46,14,54,22,62,30,
		37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28,
		35,3,43,11,51,19,59,27, 34,2,42,10,50,18,58,26,
		33,1,41,9,49,17,57,25, 32,0,40,8,48,16,56,24};
	localparam tab48_t ETab = '{
		31,0,1,2,3,4, 3,4,5,6,7,8, 7,8,9,10,11,12, 11,12,13,14,15,16,
		15,16,17,18,19,20, 19,20,21,22,23,24, 23,24,25,26,27,28, 27,28,29,30,31,0};
	localparam tab32_t PTab = '{
		15,6,19,20,28,11,27,16, 0,14,22,25,4,17,30,9,
		1,7,23,13,31,26,2,8, 18,12,29,5,21,10,3,24};
	localparam tab56_t Pc1Tab = '{
		56,48,40,32,24,16,8, 0,57,49,41,33,25,17,
		9,1,58,50,42,34,26, 18,10,2,59,51,43,35,
		62,54,46,38,30,22,14, 6,61,53,45,37,29,21,
		13,5,60,52,44,36,28, 20,12,4,27,19,11,3};
	localparam tab48_t Pc2Tab = '{
		13,16,10,23,0,4, 2,27,14,5,20,9, 22,18,11,3,25,7, 15,6,26,19,12,1,
		40,51,30,36,46,54, 29,39,50,44,32,47, 43,48,38,55,33,52, 45,41,49,35,28,31};
	localparam logic [15:0] RotTwo = 16'b0111111011111100; // bit i set: round i shifts by two

	localparam sbox_t Sbox = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Table entries count from the MSB, zero based.
	function automatic blk_t perm_ip(input blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[63-IpTab[i]];
		return r;
	endfunction

	function automatic blk_t perm_fp(input blk_t v);
		blk_t r;
		for (int i = 0; i < 64; i++) r[63-i] = v[63-FpTab[i]];
		return r;
	endfunction

	function automatic logic [55:0] perm_pc1(input blk_t v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = v[63-Pc1Tab[i]];
		return r;
	endfunction

	// Key schedule state after round rnd's shift, built from the PC-1 output.
	function automatic logic [55:0] cd_round(input logic [55:0] cd, input int rnd);
		logic [27:0] c;
		logic [27:0] d;
		int sh;
		c = cd[55:28];
		d = cd[27:0];
		sh = 0;
		for (int i = 0; i <= rnd; i++) sh += RotTwo[i] ? 2 : 1;
		for (int i = 0; i < sh; i++) begin
			c = {c[26:0], c[27]};
			d = {d[26:0], d[27]};
		end
		return {c, d};
	endfunction

	function automatic subkey_t perm_pc2(input logic [55:0] v);
		subkey_t r;
		for (int i = 0; i < 48; i++) r[47-i] = v[55-Pc2Tab[i]];
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] rv, input subkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0] six;
		for (int i = 0; i < 48; i++) x[47-i] = rv[31-ETab[i]];
		x = x ^ k;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			s[31-4*b -: 4] = Sbox[b][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[31-PTab[i]];
		return p;
	endfunction

endpackage

@@ hw/rtl/tdes_round_cell.sv @@
// One Feistel round cell: applies a round and passes valid and halves to the next cell.
module tdes_round_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_vld,
	input  tdes_pkg::blk_t   in_lr,
	input  tdes_pkg::subkey_t subkey,
	input  logic             first,
	input  logic             last,
	output logic             out_vld,
	output tdes_pkg::blk_t   out_lr
);
	import tdes_pkg::*;

	logic [31:0] l;
	logic [31:0] r;
	blk_t        nxt;
	blk_t        lr_q;
	logic        vld_q;

	always_comb begin
		// Unwrap FP at DES boundaries and apply IP of the next pass.
		if (first) {l, r} = perm_ip(in_lr);
		else {l, r} = in_lr;
		nxt = {r, l ^ feistel(r, subkey)};
		// Final round of a pass: swap halves and apply FP.
		if (last) nxt = perm_fp({nxt[31:0], nxt[63:32]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (adv) vld_q <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (adv) lr_q <= nxt;
	end

	assign out_vld = vld_q;
	assign out_lr  = lr_q;
endmodule

@@ hw/rtl/triple_des_ede2_encrypt_core.sv @@
// Top level: two-key 3DES EDE encryptor built as a 48-cell round pipeline.
// Each round is one registered cell; a word passes all 48 cells to reach cipher_block.
// Throughput: one word per cycle; the whole cell chain advances when the output is free.
// Reset: arst_n asynchronously clears every stage valid bit and both keys to zero.
// Subkeys are combinational from the keys; users change keys only when idle (unchecked).
module triple_des_ede2_encrypt_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        plain_block_valid,
	output logic        plain_block_ready,
	input  logic [63:0] plain_block,
	output logic        cipher_block_valid,
	input  logic        cipher_block_ready,
	output logic [63:0] cipher_block
);
	import tdes_pkg::*;

	blk_t        key_left_q;
	blk_t        key_right_q;
	logic        adv;
	logic [NumRounds:0] vld;
	blk_t        lr [NumRounds+1];
	logic [55:0] cd_l;
	logic [55:0] cd_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_left_q  <= '0;
			key_right_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_KEY_LEFT:  key_left_q  <= cfg_data;
				REG_KEY_RIGHT: key_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cd_l = perm_pc1(key_left_q);
	assign cd_r = perm_pc1(key_right_q);

	// Hold the chain while the last word waits.
	assign adv = !vld[NumRounds] || cipher_block_ready;
	assign plain_block_ready = adv;
	assign vld[0] = plain_block_valid;
	assign lr[0]  = plain_block;

	for (genvar g = 0; g < NumRounds; g++) begin : g_cell
		localparam int Pass = g / 16;
		localparam int Rnd  = g % 16;
		localparam int Kr   = (Pass == 1) ? 15 - Rnd : Rnd;
		subkey_t sk;
		assign sk = perm_pc2(cd_round((Pass == 1) ? cd_r : cd_l, Kr));
		tdes_round_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.in_vld  (vld[g]),
			.in_lr   (lr[g]),
			.subkey  (sk),
			.first   (Rnd == 0),
			.last    (Rnd == 15),
			.out_vld (vld[g+1]),
			.out_lr  (lr[g+1])
		);
	end

	assign cipher_block_valid = vld[NumRounds];
	assign cipher_block       = lr[NumRounds];

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_block_valid && !cipher_block_ready |=> cipher_block_valid && $stable(cipher_block))
		else $error("output word changed under stall");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!cipher_block_valid |-> plain_block_ready)
		else $error("input stalled with empty output");
	a_first_cell: assert property (@(posedge clk) disable iff (!arst_n)
		plain_block_valid && plain_block_ready |=> vld[1])
		else $error("accepted word not in first cell");
endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the two-key triple DES EDE encryptor: self-predicting, random flow control.
`timescale 1ns / 1ps

module testbench;
	import tdes_pkg::*;

	localparam int PipeDepth  = 48;
	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	reg_idx_t    cfg_idx;
	logic [63:0] cfg_data;
	logic        plain_block_valid;
	logic        plain_block_ready;
	logic [63:0] plain_block;
	logic        cipher_block_valid;
	logic        cipher_block_ready;
	logic [63:0] cipher_block;

	logic [63:0] key_l;
	logic [63:0] key_r;
	logic [63:0] cipher_expected[$];
	int          mismatch_count;
	int          cycle_count;
	int          burst_left;
	int          stall_mode;

	triple_des_ede2_encrypt_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_idx            (cfg_idx),
		.cfg_data           (cfg_data),
		.plain_block_valid  (plain_block_valid),
		.plain_block_ready  (plain_block_ready),
		.plain_block        (plain_block),
		.cipher_block_valid (cipher_block_valid),
		.cipher_block_ready (cipher_block_ready),
		.cipher_block       (cipher_block)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Single DES pass, encrypt or decrypt, big-endian bit numbering.
	function automatic logic [63:0] des_pass(input logic [63:0] blk, input logic [63:0] key,
			input bit decrypt);
		logic [55:0] cd;
		logic [27:0] c;
		logic [27:0] d;
		logic [47:0] ks[16];
		logic [63:0] v;
		logic [63:0] o;
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] t;
		logic [31:0] s;
		logic [31:0] f;
		logic [47:0] x;
		logic [47:0] k;
		logic [5:0]  six;
		for (int i = 0; i < 56; i++) cd[55-i] = key[63-Pc1Tab[i]];
		c = cd[55:28];
		d = cd[27:0];
		for (int n = 0; n < 16; n++) begin
			repeat (RotTwo[n] ? 2 : 1) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end
			cd = {c, d};
			for (int j = 0; j < 48; j++) ks[n][47-j] = cd[55-Pc2Tab[j]];
		end
		for (int i = 0; i < 64; i++) v[63-i] = blk[63-IpTab[i]];
		l = v[63:32];
		r = v[31:0];
		for (int n = 0; n < 16; n++) begin
			k = decrypt ? ks[15-n] : ks[n];
			for (int i = 0; i < 48; i++) x[47-i] = r[31-ETab[i]];
			x = x ^ k;
			for (int b = 0; b < 8; b++) begin
				six = x[47-6*b -: 6];
				s[31-4*b -: 4] = Sbox[b][{six[5], six[0]} * 16 + six[4:1]];
			end
			for (int i = 0; i < 32; i++) f[31-i] = s[31-PTab[i]];
			t = r;
			r = l ^ f;
			l = t;
		end
		v = {r, l};
		for (int i = 0; i < 64; i++) o[63-i] = v[63-FpTab[i]];
		return o;
	endfunction

	function automatic logic [63:0] ede2_encrypt(input logic [63:0] blk);
		return des_pass(des_pass(des_pass(blk, key_l, 1'b0), key_r, 1'b1), key_l, 1'b0);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// Predict on every accepted word, check on every delivered word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (plain_block_valid && plain_block_ready)
				cipher_expected.push_back(ede2_encrypt(plain_block));
			if (cipher_block_valid && cipher_block_ready) begin
				if (cipher_expected.size() == 0)
					report_mismatch("unexpected word", cipher_block, '0);
				else begin
					if (cipher_block !== cipher_expected[0])
						report_mismatch("cipher_block", cipher_block, cipher_expected[0]);
					void'(cipher_expected.pop_front());
				end
			end
		end
	end

	// Receiver stall pattern: free-flowing, light or heavy stalls, the mode chosen at random.
	always @(negedge clk) begin
		if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: cipher_block_ready <= 1'b1;
			1: cipher_block_ready <= ($urandom_range(0, 9) >= 3);
			default: cipher_block_ready <= ($urandom_range(0, 9) >= 8);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("triple_des_ede2_encrypt_core test failed");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic send_block(input logic [63:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				plain_block_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		plain_block_valid <= 1'b1;
		plain_block <= data;
		@(posedge clk);
		while (!plain_block_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		plain_block_valid <= 1'b0;
		burst_left = 0;
		while (cipher_expected.size() != 0) @(negedge clk);
		repeat (PipeDepth + 4) @(negedge clk);
	endtask

	task automatic load_keys(input logic [63:0] left, input logic [63:0] right);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_idx <= REG_KEY_LEFT;
		cfg_data <= left;
		@(negedge clk);
		cfg_idx <= REG_KEY_RIGHT;
		cfg_data <= right;
		@(negedge clk);
		cfg_we <= 1'b0;
		key_l = left;
		key_r = right;
	endtask

	task automatic test_reset_keys();
		send_block('0);
		send_block('1);
		send_block(64'h0123_4567_89ab_cdef);
		send_block(64'h8000_0000_0000_0001);
	endtask

	task automatic test_extreme_keys();
		load_keys('1, '1);
		send_block('0);
		send_block('1);
		load_keys('0, '1);
		send_block('0);
		send_block(64'h5555_5555_aaaa_aaaa);
		// parity bits only: must match the all-zero keys
		load_keys(64'h0101_0101_0101_0101, 64'h0101_0101_0101_0101);
		send_block('0);
		send_block('1);
		// equal halves reduce to single DES
		load_keys(64'h1334_5779_9bbc_dff1, 64'h1334_5779_9bbc_dff1);
		send_block(64'h0123_4567_89ab_cdef);
		load_keys(64'hfefe_fefe_fefe_fefe, 64'h0133_4557_799b_bcdf);
		send_block(64'h8000_0000_0000_0000);
		send_block(64'h0000_0000_0000_0001);
	endtask

	task automatic test_random_blocks();
		for (int phase = 0; phase < 4; phase++) begin
			if (phase == 3) load_keys('1, '0);
			else load_keys(rand64(), rand64());
			for (int i = 0; i < 210; i++) begin
				case ($urandom_range(0, 15))
					0: send_block('0);
					1: send_block('1);
					default: send_block(rand64());
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_KEY_LEFT;
		cfg_data = '0;
		plain_block_valid = 1'b0;
		plain_block = '0;
		cipher_block_ready = 1'b0;
		stall_mode = 0;
		cycle_count = 0;
		mismatch_count = 0;
		burst_left = 0;
		key_l = '0;
		key_r = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_keys();
		test_extreme_keys();
		test_random_blocks();
		wait_drained();
		if (mismatch_count == 0 && cipher_expected.size() == 0)
			$display("triple_des_ede2_encrypt_core test passed");
		else
			$display("triple_des_ede2_encrypt_core test failed");
		$finish;
	end

endmodule
